// File: sv/tga_rle_pkg.sv
`default_nettype none
package tga_rle_pkg;

	localparam int BYTE_W       = 8;
	localparam int COLOR_W      = 32;
	localparam int TOTAL_W      = 32;
	localparam int BPP_W        = 3;
	localparam int CFG_INDEX_W  = 1;
	localparam int CFG_DATA_W   = 32;
	localparam int QUEUE_DEPTH  = 4;
	localparam int QUEUE_PTR_W  = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CNT_W  = $clog2(QUEUE_DEPTH + 1);

	// register indexes on the configuration port
	localparam logic [CFG_INDEX_W-1:0] REG_BYTES_PER_PIXEL = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_PIXEL_TOTAL     = 1'd1;

	localparam logic [BPP_W-1:0]  BPP_RESET   = 3'd3;
	localparam logic [BPP_W-1:0]  BPP_ALPHA   = 3'd4;
	localparam logic [TOTAL_W-1:0] TOTAL_RESET = 32'd1;

	localparam logic [BYTE_W-1:0] RAW_LIMIT    = 8'd128;
	localparam logic [BYTE_W-1:0] REPEAT_BIAS  = 8'd127;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       image_start;
	} in_item_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] alpha;
		logic [7:0] run_count;
		logic       run_clamped;
		logic       last_run;
	} out_item_t;

	// what the front hands to the back for each byte that matters downstream
	typedef struct packed {
		logic       start;
		logic       pixel;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] alpha;
		logic [7:0] count;
	} event_t;

endpackage
`default_nettype wire

// File: sv/tga_rle_front.sv
`default_nettype none
module tga_rle_front (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          fire,
	input  wire tga_rle_pkg::in_item_t         item,
	input  wire logic [tga_rle_pkg::BPP_W-1:0] bytes_per_pixel,
	output logic                               push,
	output tga_rle_pkg::event_t                push_event
);
	import tga_rle_pkg::*;

	localparam logic PH_HEADER = 1'b0;
	localparam logic PH_PIXEL  = 1'b1;

	logic                phase_q;
	logic [7:0]          packet_left_q;
	logic                repeat_q;
	logic [1:0]          bip_q;
	logic [COLOR_W-1:0]  gather_q;

	logic                phase_e;
	logic [1:0]          bip_e;
	logic [COLOR_W-1:0]  gather_e;
	logic [COLOR_W-1:0]  gather_n;
	logic                size4;
	logic                finish;
	logic [7:0]          left_dec;

	always_comb begin
		phase_e  = item.image_start ? PH_HEADER : phase_q;
		bip_e    = item.image_start ? 2'd0 : bip_q;
		gather_e = item.image_start ? '0 : gather_q;
		size4    = (bytes_per_pixel == BPP_ALPHA);
		gather_n = gather_e;
		unique case (bip_e)
			2'd0: gather_n[7:0]   = item.data_byte;
			2'd1: gather_n[15:8]  = item.data_byte;
			2'd2: gather_n[23:16] = item.data_byte;
			2'd3: gather_n[31:24] = item.data_byte;
			default: gather_n = gather_e;
		endcase
		// pixel ends once the byte index reaches the pixel size less one
		finish   = (phase_e == PH_PIXEL) &&
			!(({1'b0, bip_e} + 3'd1) < (size4 ? 3'd4 : 3'd3));
		left_dec = packet_left_q - 8'd1;
	end

	always_comb begin
		push                 = fire && (item.image_start || finish);
		push_event.start     = item.image_start;
		push_event.pixel     = finish;
		push_event.red       = gather_n[23:16];
		push_event.green     = gather_n[15:8];
		push_event.blue      = gather_n[7:0];
		push_event.alpha     = size4 ? gather_n[31:24] : 8'd0;
		push_event.count     = repeat_q ? packet_left_q : 8'd1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_HEADER;
			packet_left_q <= '0;
			repeat_q      <= 1'b0;
			bip_q         <= '0;
			gather_q      <= '0;
		end else if (fire) begin
			if (phase_e == PH_HEADER) begin
				if (item.data_byte < RAW_LIMIT) begin
					repeat_q      <= 1'b0;
					packet_left_q <= item.data_byte + 8'd1;
				end else begin
					repeat_q      <= 1'b1;
					packet_left_q <= item.data_byte - REPEAT_BIAS;
				end
				bip_q    <= '0;
				gather_q <= '0;
				phase_q  <= PH_PIXEL;
			end else if (!finish) begin
				bip_q    <= bip_e + 2'd1;
				gather_q <= gather_n;
			end else begin
				// once the image is done the back drops further pixels
				bip_q    <= '0;
				gather_q <= '0;
				if (repeat_q) begin
					packet_left_q <= '0;
					phase_q       <= PH_HEADER;
				end else begin
					packet_left_q <= left_dec;
					phase_q       <= (left_dec == 8'd0) ? PH_HEADER : PH_PIXEL;
				end
			end
		end
	end

endmodule
`default_nettype wire

// File: sv/tga_rle_queue.sv
`default_nettype none
module tga_rle_queue (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                push,
	input  wire tga_rle_pkg::event_t push_event,
	input  wire logic                pop,
	output logic                     full,
	output logic                     not_empty,
	output tga_rle_pkg::event_t      head
);
	import tga_rle_pkg::*;

	event_t                   entry_q [QUEUE_DEPTH];
	logic [QUEUE_PTR_W-1:0]   wr_ptr_q;
	logic [QUEUE_PTR_W-1:0]   rd_ptr_q;
	logic [QUEUE_CNT_W-1:0]   count_q;
	logic                     do_push;
	logic                     do_pop;

	assign full      = (count_q == QUEUE_CNT_W'(QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign head      = entry_q[rd_ptr_q];
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;

	always_ff @(posedge clk) begin
		if (do_push)
			entry_q[wr_ptr_q] <= push_event;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= wr_ptr_q + QUEUE_PTR_W'(1);
			if (do_pop)
				rd_ptr_q <= rd_ptr_q + QUEUE_PTR_W'(1);
			unique case ({do_push, do_pop})
				2'b10:   count_q <= count_q + QUEUE_CNT_W'(1);
				2'b01:   count_q <= count_q - QUEUE_CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule
`default_nettype wire

// File: sv/tga_rle_back.sv
`default_nettype none
module tga_rle_back (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            avail,
	input  wire tga_rle_pkg::event_t             head,
	input  wire logic [tga_rle_pkg::TOTAL_W-1:0] pixel_total,
	output logic                                 pop,
	output logic                                 out_valid,
	input  wire logic                            out_stall,
	output tga_rle_pkg::out_item_t               out_data
);
	import tga_rle_pkg::*;

	logic                done_q;
	logic [TOTAL_W-1:0]  pixels_done_q;
	logic                out_valid_q;
	out_item_t           out_q;

	logic [TOTAL_W-1:0]  total;
	logic [TOTAL_W-1:0]  left;
	logic                exhausted;
	logic                clamp;
	logic                last;
	logic [7:0]          count;
	logic                live;
	logic                produces;
	logic                out_free;

	always_comb begin
		total     = (pixel_total == '0) ? TOTAL_RESET : pixel_total;
		exhausted = (pixels_done_q >= total);
		left      = total - pixels_done_q;
		clamp     = ({{(TOTAL_W-8){1'b0}}, head.count} > left);
		count     = clamp ? left[7:0] : head.count;
		// done + count reaches the total exactly when count covers what is left
		last      = ({{(TOTAL_W-8){1'b0}}, head.count} >= left);
		live      = head.pixel && !head.start && !done_q;
		produces  = live && !exhausted;
		out_free  = !out_valid_q || !out_stall;
		pop       = avail && (!produces || out_free);
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q        <= 1'b0;
			pixels_done_q <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			out_valid_q <= (pop && produces) || (out_valid_q && out_stall);
			if (pop) begin
				if (head.start) begin
					done_q        <= 1'b0;
					pixels_done_q <= '0;
				end else if (live && exhausted) begin
					done_q <= 1'b1;
				end else if (produces) begin
					pixels_done_q <= pixels_done_q + {{(TOTAL_W-8){1'b0}}, count};
					if (last)
						done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && produces) begin
			out_q.red         <= head.red;
			out_q.green       <= head.green;
			out_q.blue        <= head.blue;
			out_q.alpha       <= head.alpha;
			out_q.run_count   <= count;
			out_q.run_clamped <= clamp;
			out_q.last_run    <= last;
		end
	end

endmodule
`default_nettype wire

// File: sv/tga_rle_pixel_decoder_core.sv
// run-length tga pixel decoder
// in_valid/in_stall carry one coded byte per transaction, with image_start
// set on the first header byte of a new image. out_valid/out_stall carry one
// decoded pixel per transaction: rgba, its run count, a clamp flag and a
// last-run mark on the transaction that completes the image.
// a front stage parses packet headers and gathers colour bytes, a four-deep
// event queue decouples it from the back stage, which counts pixels, clamps
// runs and holds the output register.
// throughput: one byte per cycle while the queue has room; one result per
// cycle at most, set by the output register.
// out_valid rises once the event pushed for the final colour byte of its
// pixel has passed the queue and been registered by the back stage.
// when the receiver stalls the output holds; once the queue fills, in_stall
// rises and input bytes wait.
// the user writes bytes_per_pixel (index 0), pixel_total (index 1) via
// cfg_we/cfg_index/cfg_data only while the block is idle; not enforced.
// reset sets 24-bit pixels, a total of one pixel and an empty queue.
`default_nettype none
module tga_rle_pixel_decoder_core (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                in_valid,
	output logic                                     in_stall,
	input  wire tga_rle_pkg::in_item_t               in_data,
	output logic                                     out_valid,
	input  wire logic                                out_stall,
	output tga_rle_pkg::out_item_t                   out_data,
	input  wire logic                                cfg_we,
	input  wire logic [tga_rle_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [tga_rle_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import tga_rle_pkg::*;

	logic [BPP_W-1:0]   bytes_per_pixel_q;
	logic [TOTAL_W-1:0] pixel_total_q;

	logic   fire;
	logic   push;
	event_t push_event;
	logic   pop;
	logic   full;
	logic   not_empty;
	event_t head;

	assign in_stall = full;
	assign fire     = in_valid && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bytes_per_pixel_q <= BPP_RESET;
			pixel_total_q     <= TOTAL_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_BYTES_PER_PIXEL: bytes_per_pixel_q <= cfg_data[BPP_W-1:0];
				REG_PIXEL_TOTAL:     pixel_total_q     <= cfg_data[TOTAL_W-1:0];
				default:             pixel_total_q     <= pixel_total_q;
			endcase
		end
	end

	tga_rle_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.fire            (fire),
		.item            (in_data),
		.bytes_per_pixel (bytes_per_pixel_q),
		.push            (push),
		.push_event      (push_event)
	);

	tga_rle_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_event (push_event),
		.pop        (pop),
		.full       (full),
		.not_empty  (not_empty),
		.head       (head)
	);

	tga_rle_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.avail       (not_empty),
		.head        (head),
		.pixel_total (pixel_total_q),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_data    (out_data)
	);

endmodule
`default_nettype wire
